// ===== src/csv_field_splitter_macros.svh =====
// Assertion macros shared by the checker of the CSV field splitter.
`ifndef CSV_FIELD_SPLITTER_MACROS_SVH
`define CSV_FIELD_SPLITTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CSF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define CSF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/csf_pkg.sv =====
// Types, codes and constants of the CSV field splitter.
package csf_pkg;

   localparam int CHAR_W = 8;
   localparam int KIND_W = 2;
   localparam int CSR_IDX_W = 2;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_CHAR      = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIELD_END = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MISSING   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_LINE_END  = 2'd3;

   // Input commands.
   localparam logic CMD_CHAR     = 1'b0;
   localparam logic CMD_LINE_END = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SEPARATOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_QUOTE     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ESCAPE    = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [CHAR_W-1:0] SEPARATOR_RESET = 8'd44;
   localparam logic [CHAR_W-1:0] QUOTE_RESET     = 8'd34;
   localparam logic [CHAR_W-1:0] ESCAPE_RESET    = 8'd92;

   // Result queue geometry.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAR_W-1:0] char_out;
      logic              unclosed_quote;
      logic              last_of_run;
   } tok_type;

   typedef struct packed {
      logic [1:0] count;
      tok_type    tok0;
      tok_type    tok1;
   } tok_pair_type;

   typedef struct packed {
      logic in_quotes;
      logic escape_pending;
      logic field_has_content;
      logic after_separator;
   } parse_state_type;

   typedef struct packed {
      logic [CHAR_W-1:0] separator_byte;
      logic [CHAR_W-1:0] quote_byte;
      logic [CHAR_W-1:0] escape_byte;
   } csr_type;

endpackage

// ===== src/csf_req_if.sv =====
// Input byte channel of the CSV field splitter.
interface csf_req_if;
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [csf_pkg::CHAR_W-1:0] char_in;

   modport source (output valid, output cmd, output char_in, input ready);
   modport sink (input valid, input cmd, input char_in, output ready);
endinterface

// ===== src/csf_rsp_if.sv =====
// Result token channel of the CSV field splitter.
interface csf_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [csf_pkg::KIND_W-1:0] kind;
   logic [csf_pkg::CHAR_W-1:0] char_out;
   logic                      unclosed_quote;
   logic                      last_of_run;

   modport source (output valid, output kind, output char_out, output unclosed_quote,
                   output last_of_run, input ready);
   modport sink (input valid, input kind, input char_out, input unclosed_quote,
                 input last_of_run, output ready);
endinterface

// ===== src/csf_csr_if.sv =====
// Configuration write channel of the CSV field splitter.
interface csf_csr_if;
   logic                         valid;
   logic                         ready;
   logic [csf_pkg::CSR_IDX_W-1:0] index;
   logic [csf_pkg::CHAR_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/csf_decode.sv =====
// Token decode: turns one byte or end-of-line beat into tokens and the next parse state.
module csf_decode (
   input  logic                      cmd,
   input  logic [csf_pkg::CHAR_W-1:0] char_in,
   input  csf_pkg::csr_type          csr,
   input  csf_pkg::parse_state_type  state,
   output csf_pkg::tok_pair_type     toks,
   output csf_pkg::parse_state_type  state_next
);
   import csf_pkg::*;

   tok_type blank_tok;

   assign blank_tok = '{kind: KIND_CHAR, char_out: '0, unclosed_quote: 1'b0,
                        last_of_run: 1'b0};

   // Escape is tested first, then quote, then separator.
   always_comb begin
      toks       = '{count: 2'd0, tok0: blank_tok, tok1: blank_tok};
      state_next = state;
      if (cmd == CMD_LINE_END) begin
         // Close an open field or flag a trailing missing field, then end the line.
         if (state.field_has_content || state.after_separator) begin
            toks.count           = 2'd2;
            toks.tok0.kind       = state.field_has_content ? KIND_FIELD_END : KIND_MISSING;
            toks.tok1.kind       = KIND_LINE_END;
            toks.tok1.unclosed_quote = state.in_quotes;
            toks.tok1.last_of_run    = 1'b1;
         end else begin
            toks.count           = 2'd1;
            toks.tok0.kind       = KIND_LINE_END;
            toks.tok0.unclosed_quote = state.in_quotes;
            toks.tok0.last_of_run    = 1'b1;
         end
         state_next = '0;
      end else begin
         priority if (state.escape_pending) begin
            toks.count                   = 2'd1;
            toks.tok0.char_out           = char_in;
            toks.tok0.last_of_run        = 1'b1;
            state_next.escape_pending    = 1'b0;
            state_next.after_separator   = 1'b0;
            state_next.field_has_content = 1'b1;
         end else if (char_in == csr.escape_byte) begin
            state_next.escape_pending  = 1'b1;
            state_next.after_separator = 1'b0;
         end else if (char_in == csr.quote_byte) begin
            state_next.in_quotes       = !state.in_quotes;
            state_next.after_separator = 1'b0;
         end else if (char_in == csr.separator_byte && !state.in_quotes) begin
            toks.count                   = 2'd1;
            toks.tok0.kind               = state.field_has_content ? KIND_FIELD_END
                                                                   : KIND_MISSING;
            toks.tok0.last_of_run        = 1'b1;
            state_next.field_has_content = 1'b0;
            state_next.after_separator   = 1'b1;
         end else begin
            toks.count                   = 2'd1;
            toks.tok0.char_out           = char_in;
            toks.tok0.last_of_run        = 1'b1;
            state_next.field_has_content = 1'b1;
            state_next.after_separator   = 1'b0;
         end
      end
   end
endmodule

// ===== src/csf_token_queue.sv =====
// Small result queue: takes up to two tokens a cycle, delivers one beat a cycle while out_ready is high.
module csf_token_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_count,
   input  csf_pkg::tok_type push_tok0,
   input  csf_pkg::tok_type push_tok1,
   output logic             room_two,
   output logic             out_valid,
   input  logic             out_ready,
   output csf_pkg::tok_type out_tok
);
   import csf_pkg::*;

   tok_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   wr_ptr_next;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                pop;

   assign pop         = out_valid && out_ready;
   assign out_valid   = (count_ff != '0);
   assign out_tok     = entry_ff[rd_ptr_ff];
   assign room_two    = (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign wr_ptr_next = QPTR_W'(wr_ptr_ff + 1'b1);

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = QPTR_W'(wr_ptr_ff + QPTR_W'(push_count));
      rd_ptr_in = pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = QCNT_W'(count_ff + QCNT_W'(push_count) - QCNT_W'(pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Token storage: first token at the write pointer, second right after it.
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_tok0;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push_tok1;
      end
   end
endmodule

// ===== src/csv_field_splitter.sv =====
// Top level of the CSV field splitter: input register, parse state, decode and result queue.
//
//   channel   dir   beat contents                                   accepted when
//   req_if    in    cmd, char_in                                    valid && ready
//   rsp_if    out   kind, char_out, unclosed_quote, last_of_run     valid && ready
//   csr_if    in    index, data (separator, quote, escape bytes)    valid && ready
//
// A byte beat is decoded from the input register in the cycle after it is taken; its tokens
// enter the result queue once it has room and reach rsp_if from the queue's registers.
// The input register advances only when the four-entry result queue has room for two tokens;
// with room, one input beat is taken every cycle. The single-token output port gives one token
// per cycle while rsp_if.ready is high, so a two-token end-of-line beat takes two beats.
// Reset is synchronous; it clears the parse state and the queue and returns the configuration
// registers to their default bytes.
// Configuration writes are always accepted and take effect on the next cycle.
module csv_field_splitter (
   input logic        clock,
   input logic        reset,
   csf_req_if.sink    req_if,
   csf_rsp_if.source  rsp_if,
   csf_csr_if.sink    csr_if
);
   import csf_pkg::*;

   csr_type           csr_ff;
   csr_type           csr_in;
   parse_state_type   state_ff;
   parse_state_type   state_in;
   parse_state_type   state_next;
   logic              s1_valid_ff;
   logic              s1_valid_in;
   logic              s1_cmd_ff;
   logic [CHAR_W-1:0] s1_char_ff;
   logic              accept;
   logic              advance;
   logic              room_two;
   logic [1:0]        push_count;
   tok_pair_type      toks;
   tok_type           out_tok;

   // Configuration registers; an index past the list is ignored.
   assign csr_if.ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_SEPARATOR: csr_in.separator_byte = csr_if.data;
            CSR_QUOTE:     csr_in.quote_byte     = csr_if.data;
            CSR_ESCAPE:    csr_in.escape_byte    = csr_if.data;
            default:       csr_in                = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{separator_byte: SEPARATOR_RESET, quote_byte: QUOTE_RESET,
                     escape_byte: ESCAPE_RESET};
      end else begin
         csr_ff <= csr_in;
      end
   end

   // Input register: holds one beat until the queue has room for its tokens.
   assign advance      = s1_valid_ff && room_two;
   assign req_if.ready = !s1_valid_ff || advance;
   assign accept       = req_if.valid && req_if.ready;
   assign s1_valid_in  = accept || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= req_if.cmd;
         s1_char_ff <= req_if.char_in;
      end
   end

   // Decode against the current parse state.
   csf_decode u_decode (
      .cmd        (s1_cmd_ff),
      .char_in    (s1_char_ff),
      .csr        (csr_ff),
      .state      (state_ff),
      .toks       (toks),
      .state_next (state_next)
   );

   assign state_in   = advance ? state_next : state_ff;
   assign push_count = advance ? toks.count : 2'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result queue feeding the output channel.
   csf_token_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_tok0  (toks.tok0),
      .push_tok1  (toks.tok1),
      .room_two   (room_two),
      .out_valid  (rsp_if.valid),
      .out_ready  (rsp_if.ready),
      .out_tok    (out_tok)
   );

   assign rsp_if.kind           = out_tok.kind;
   assign rsp_if.char_out       = out_tok.char_out;
   assign rsp_if.unclosed_quote = out_tok.unclosed_quote;
   assign rsp_if.last_of_run    = out_tok.last_of_run;
endmodule

// ===== src/csf_checker.sv =====
// Port-level checker of the CSV field splitter and its bind to the top level.
`include "csv_field_splitter_macros.svh"

module csf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [csf_pkg::KIND_W-1:0] rsp_kind,
   input logic [csf_pkg::CHAR_W-1:0] rsp_char_out,
   input logic                      rsp_unclosed_quote,
   input logic                      rsp_last_of_run
);
   import csf_pkg::*;

   // A stalled result beat stays offered with the same token.
   `CSF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_kind, rsp_char_out, rsp_unclosed_quote, rsp_last_of_run}), "result beat changed while stalled")

   // Nothing is offered in the cycle after reset.
   `CSF_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result offered right after reset")

   // Only field characters carry a byte.
   `CSF_ASSERT_NOW(a_char_zero, clock, reset, rsp_valid && rsp_kind != KIND_CHAR, rsp_char_out == '0, "non-character token carries a byte")

   // The open-quote flag appears only on a line end.
   `CSF_ASSERT_NOW(a_unclosed_line_end, clock, reset, rsp_valid && rsp_unclosed_quote, rsp_kind == KIND_LINE_END, "open-quote flag on a token other than line end")

   // A line end is always the final token of its input beat.
   `CSF_ASSERT_NOW(a_line_end_last, clock, reset, rsp_valid && rsp_kind == KIND_LINE_END, rsp_last_of_run, "line end not marked as final token")
endmodule

bind csv_field_splitter csf_checker u_csf_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_kind           (rsp_if.kind),
   .rsp_char_out       (rsp_if.char_out),
   .rsp_unclosed_quote (rsp_if.unclosed_quote),
   .rsp_last_of_run    (rsp_if.last_of_run)
);

// ===== test/csf_token_checker.sv =====
// Token checker of the CSV field splitter: tracks the line syntax and parse state and scores tokens.
module csf_token_checker (
   input  logic clock,
   input  logic reset,
   csf_req_if   req_if,
   csf_rsp_if   rsp_if,
   csf_csr_if   csr_if,
   output int   fail_count,
   output int   pending_tokens
);
   import csf_pkg::*;

   // Shadow of the line syntax registers.
   logic [CHAR_W-1:0] sep_char;
   logic [CHAR_W-1:0] quote_char;
   logic [CHAR_W-1:0] esc_char;

   // Shadow of the tokenizer state.
   logic quoted;
   logic literal_next;
   logic field_open;
   logic just_separated;

   tok_type expected_tokens[$];
   tok_type exp_tok;
   int      errors;

   task automatic queue_token(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
                              logic unclosed, logic last);
      tok_type t;
      t.kind           = kind;
      t.char_out       = ch;
      t.unclosed_quote = unclosed;
      t.last_of_run    = last;
      expected_tokens.insert(expected_tokens.size(), t);
   endtask

   // Work out the tokens that one input beat causes and advance the state.
   task automatic tokenize_beat(logic cmd, logic [CHAR_W-1:0] ch);
      if (cmd == CMD_LINE_END) begin
         // Close an open field, or mark the field after a trailing separator as missing.
         if (field_open)
            queue_token(KIND_FIELD_END, '0, 1'b0, 1'b0);
         else if (just_separated)
            queue_token(KIND_MISSING, '0, 1'b0, 1'b0);
         queue_token(KIND_LINE_END, '0, quoted, 1'b1);
         quoted         = 1'b0;
         literal_next   = 1'b0;
         field_open     = 1'b0;
         just_separated = 1'b0;
      end else if (literal_next) begin
         // The byte after an escape is a field character whatever its value.
         literal_next   = 1'b0;
         just_separated = 1'b0;
         field_open     = 1'b1;
         queue_token(KIND_CHAR, ch, 1'b0, 1'b1);
      end else if (ch == esc_char) begin
         literal_next   = 1'b1;
         just_separated = 1'b0;
      end else if (ch == quote_char) begin
         quoted         = !quoted;
         just_separated = 1'b0;
      end else if (ch == sep_char && !quoted) begin
         queue_token(field_open ? KIND_FIELD_END : KIND_MISSING, '0, 1'b0, 1'b1);
         field_open     = 1'b0;
         just_separated = 1'b1;
      end else begin
         field_open     = 1'b1;
         just_separated = 1'b0;
         queue_token(KIND_CHAR, ch, 1'b0, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sep_char       = SEPARATOR_RESET;
         quote_char     = QUOTE_RESET;
         esc_char       = ESCAPE_RESET;
         quoted         = 1'b0;
         literal_next   = 1'b0;
         field_open     = 1'b0;
         just_separated = 1'b0;
         expected_tokens.delete();
         errors         = 0;
      end else begin
         // Register writes; an unused index is ignored.
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_SEPARATOR: sep_char = csr_if.data;
               CSR_QUOTE:     quote_char = csr_if.data;
               CSR_ESCAPE:    esc_char = csr_if.data;
               default: ;
            endcase
         end

         // Compare each result beat with the oldest expected token.
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_tokens.size() == 0) begin
               $error("unexpected token: kind %0d, char_out %0d, unclosed_quote %0d, last_of_run %0d",
                      rsp_if.kind, rsp_if.char_out, rsp_if.unclosed_quote, rsp_if.last_of_run);
               errors++;
            end else begin
               exp_tok = expected_tokens.pop_front();
               if (rsp_if.kind !== exp_tok.kind) begin
                  $error("kind: expected %0d, actual %0d", exp_tok.kind, rsp_if.kind);
                  errors++;
               end
               if (rsp_if.char_out !== exp_tok.char_out) begin
                  $error("char_out: expected %0d, actual %0d", exp_tok.char_out, rsp_if.char_out);
                  errors++;
               end
               if (rsp_if.unclosed_quote !== exp_tok.unclosed_quote) begin
                  $error("unclosed_quote: expected %0d, actual %0d",
                         exp_tok.unclosed_quote, rsp_if.unclosed_quote);
                  errors++;
               end
               if (rsp_if.last_of_run !== exp_tok.last_of_run) begin
                  $error("last_of_run: expected %0d, actual %0d",
                         exp_tok.last_of_run, rsp_if.last_of_run);
                  errors++;
               end
            end
         end

         // Predict the tokens of an accepted input beat.
         if (req_if.valid && req_if.ready)
            tokenize_beat(req_if.cmd, req_if.char_in);
      end
      fail_count     <= errors;
      pending_tokens <= expected_tokens.size();
   end

endmodule

// ===== test/tb_csv_field_splitter.sv =====
// Testbench top of the CSV field splitter: clock, reset, byte stimulus, syntax writes and verdict.
module tb_csv_field_splitter;
   import csf_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int SEGMENT_BEATS = 28;
   // Index past the last register, written to check that it is ignored.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int cycle_count = 0;
   int fail_count;
   int pending_tokens;

   // Line syntax currently programmed, used to shape the random lines.
   csr_type line_syntax;

   csf_req_if req_if();
   csf_rsp_if rsp_if();
   csf_csr_if csr_if();

   csv_field_splitter dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   csf_token_checker token_checker (
      .clock          (clock),
      .reset          (reset),
      .req_if         (req_if),
      .rsp_if         (rsp_if),
      .csr_if         (csr_if),
      .fail_count     (fail_count),
      .pending_tokens (pending_tokens)
   );

   always #5 clock = ~clock;

   // Receiver side: stalls at random at the rate of the current phase.
   always @(posedge clock)
      rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("csv_field_splitter: mismatch");
         $finish;
      end
   end

   // Present one beat after a random gap and hold it until it is taken.
   task automatic send_beat(logic cmd, logic [CHAR_W-1:0] ch);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.cmd     <= cmd;
      req_if.char_in <= ch;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Send the bytes of a text line followed by its end of line.
   task automatic send_line(string text);
      for (int i = 0; i < text.len(); i++)
         send_beat(CMD_CHAR, text[i]);
      send_beat(CMD_LINE_END, '0);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CHAR_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   // Program all three syntax bytes plus a write to the unused index.
   task automatic apply_syntax(csr_type s);
      write_csr(CSR_SEPARATOR, s.separator_byte);
      write_csr(CSR_QUOTE, s.quote_byte);
      write_csr(CSR_ESCAPE, s.escape_byte);
      write_csr(CSR_UNUSED, CHAR_W'($urandom_range(255)));
      csr_if.valid <= 1'b0;
      line_syntax = s;
   endtask

   // Stop sending and wait until the block has nothing left in flight. The expected count
   // is registered, so it is read only after the edge that took the last beat has passed.
   task automatic settle();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_tokens != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random syntax, with coinciding bytes fairly often to exercise the priority.
   function automatic csr_type random_syntax();
      csr_type s;
      s.separator_byte = CHAR_W'($urandom_range(255));
      s.quote_byte = ($urandom_range(3) == 0) ? s.separator_byte : CHAR_W'($urandom_range(255));
      if ($urandom_range(3) == 0)
         s.escape_byte = $urandom_range(1) ? s.separator_byte : s.quote_byte;
      else
         s.escape_byte = CHAR_W'($urandom_range(255));
      return s;
   endfunction

   // A byte of a well-formed line: mostly syntax bytes, otherwise any value.
   function automatic logic [CHAR_W-1:0] pick_line_byte();
      int roll;
      roll = $urandom_range(99);
      if (roll < 30) return line_syntax.separator_byte;
      if (roll < 45) return line_syntax.quote_byte;
      if (roll < 55) return line_syntax.escape_byte;
      return CHAR_W'($urandom_range(255));
   endfunction

   // Random lines with random content, and now and then a stray beat.
   task automatic random_segment(int beats);
      int sent;
      int len;
      sent = 0;
      while (sent < beats) begin
         if ($urandom_range(9) == 0) begin
            send_beat(logic'($urandom_range(1)), CHAR_W'($urandom_range(255)));
            sent++;
         end else begin
            len = $urandom_range(10);
            for (int i = 0; i < len; i++)
               send_beat(CMD_CHAR, pick_line_byte());
            send_beat(CMD_LINE_END, CHAR_W'($urandom_range(255)));
            sent += len + 1;
         end
      end
   endtask

   initial begin
      csr_type next_syntax;
      req_if.valid   = 1'b0;
      req_if.cmd     = CMD_CHAR;
      req_if.char_in = '0;
      csr_if.valid   = 1'b0;
      csr_if.index   = CSR_SEPARATOR;
      csr_if.data    = '0;
      line_syntax.separator_byte = SEPARATOR_RESET;
      line_syntax.quote_byte     = QUOTE_RESET;
      line_syntax.escape_byte    = ESCAPE_RESET;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed lines under the reset syntax.
      send_line("");            // empty line gives only a line end
      send_line("a,b");
      send_line(",,");          // missing fields, then a missing one at the end
      send_line("\"x,y\"");     // separator inside quotes is a character
      send_line("\\,\\");       // escaped separator, escape at end of line dropped
      send_line("\"q");         // quote left open
      send_line("a,");          // trailing separator
      send_beat(CMD_CHAR, 8'h00);
      send_beat(CMD_CHAR, 8'hFF);
      send_beat(CMD_LINE_END, 8'hFF);

      // Random phases with different idling, each split into syntax segments.
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin sender_idle_pct = 0;  receiver_stall_pct <= 0;  end
            1: begin sender_idle_pct = 57; receiver_stall_pct <= 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct <= 57; end
            default: begin sender_idle_pct = 25; receiver_stall_pct <= 25; end
         endcase
         for (int seg = 0; seg < 4; seg++) begin
            settle();
            next_syntax = random_syntax();
            if (seg == 0) begin
               // Extremes, full coincidence or the reset syntax first in each phase.
               case (p)
                  0: begin
                     next_syntax.separator_byte = 8'h00;
                     next_syntax.quote_byte     = 8'hFF;
                     next_syntax.escape_byte    = 8'h80;
                  end
                  1: begin
                     next_syntax.separator_byte = 8'hFF;
                     next_syntax.quote_byte     = 8'h00;
                     next_syntax.escape_byte    = 8'h7F;
                  end
                  2: begin
                     next_syntax.separator_byte = 8'h41;
                     next_syntax.quote_byte     = 8'h41;
                     next_syntax.escape_byte    = 8'h41;
                  end
                  default: begin
                     next_syntax.separator_byte = SEPARATOR_RESET;
                     next_syntax.quote_byte     = QUOTE_RESET;
                     next_syntax.escape_byte    = ESCAPE_RESET;
                  end
               endcase
            end
            apply_syntax(next_syntax);
            random_segment(SEGMENT_BEATS);
         end
      end

      // Drain and give the verdict.
      settle();
      if (pending_tokens != 0)
         $error("%0d expected tokens never arrived", pending_tokens);
      if (fail_count == 0 && pending_tokens == 0)
         $display("csv_field_splitter: match");
      else
         $display("csv_field_splitter: mismatch");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/csf_pkg.sv
src/csf_req_if.sv
src/csf_rsp_if.sv
src/csf_csr_if.sv
src/csf_decode.sv
src/csf_token_queue.sv
src/csv_field_splitter.sv
src/csf_checker.sv
test/csf_token_checker.sv
test/tb_csv_field_splitter.sv
